>>> hw/rtl/qsao_pkg.sv
// Shared constants and types for the quad separating-axis overlap core.
package qsao_pkg;

    localparam int NUM_CORNERS  = 4;
    localparam int NUM_EDGES    = 4;
    localparam int ALL_CORNERS  = 2 * NUM_CORNERS;
    localparam int EDGE_BITS    = $clog2(NUM_EDGES);
    localparam int FIELD_BITS   = 24;
    localparam int S_TDATA_BITS = 2 * NUM_CORNERS * FIELD_BITS;
    localparam int S_TUSER_BITS = 1;
    localparam int M_TDATA_BITS = 8;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TEST = 1'b1
    } kind_t;

    typedef logic [EDGE_BITS-1:0] edge_idx_t;

endpackage

>>> hw/rtl/qsao_axis.sv
// Reference quad store and edge-normal axis stage.
module qsao_axis #(
    parameter int COORD_BITS = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  qsao_pkg::kind_t              in_kind,
    input  logic signed [COORD_BITS-1:0] in_x [qsao_pkg::NUM_CORNERS],
    input  logic signed [COORD_BITS-1:0] in_y [qsao_pkg::NUM_CORNERS],
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COORD_BITS:0]   out_ax [qsao_pkg::NUM_EDGES],
    output logic signed [COORD_BITS:0]   out_ay [qsao_pkg::NUM_EDGES],
    output logic signed [COORD_BITS-1:0] out_x [qsao_pkg::ALL_CORNERS],
    output logic signed [COORD_BITS-1:0] out_y [qsao_pkg::ALL_CORNERS]
);
    import qsao_pkg::*;

    logic signed [COORD_BITS-1:0] ref_x_reg [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] ref_y_reg [NUM_CORNERS];
    logic                         valid_reg;
    logic signed [COORD_BITS:0]   ax_reg [NUM_EDGES];
    logic signed [COORD_BITS:0]   ay_reg [NUM_EDGES];
    logic signed [COORD_BITS:0]   ax_next [NUM_EDGES];
    logic signed [COORD_BITS:0]   ay_next [NUM_EDGES];
    logic signed [COORD_BITS-1:0] x_reg [ALL_CORNERS];
    logic signed [COORD_BITS-1:0] y_reg [ALL_CORNERS];
    logic                         load_fire;

    assign in_ready  = !valid_reg || out_ready;
    assign load_fire = in_valid && in_ready && (in_kind == KIND_LOAD);

    // Axis of edge i -> i+1 is (-(y1 - y0), x1 - x0)
    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_axis
        localparam int J = (e + 1) % NUM_CORNERS;
        assign ax_next[e] = (COORD_BITS+1)'(ref_y_reg[e]) - (COORD_BITS+1)'(ref_y_reg[J]);
        assign ay_next[e] = (COORD_BITS+1)'(ref_x_reg[J]) - (COORD_BITS+1)'(ref_x_reg[e]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CORNERS; c++) begin
                ref_x_reg[c] <= '0;
                ref_y_reg[c] <= '0;
            end
        end else begin
            // Load words update the store and drop out here
            if (in_ready) begin
                valid_reg <= in_valid && (in_kind == KIND_TEST);
            end
            if (load_fire) begin
                for (int c = 0; c < NUM_CORNERS; c++) begin
                    ref_x_reg[c] <= in_x[c];
                    ref_y_reg[c] <= in_y[c];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            for (int e = 0; e < NUM_EDGES; e++) begin
                ax_reg[e] <= ax_next[e];
                ay_reg[e] <= ay_next[e];
            end
            for (int c = 0; c < NUM_CORNERS; c++) begin
                x_reg[c]               <= ref_x_reg[c];
                y_reg[c]               <= ref_y_reg[c];
                x_reg[c + NUM_CORNERS] <= in_x[c];
                y_reg[c + NUM_CORNERS] <= in_y[c];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_ax    = ax_reg;
    assign out_ay    = ay_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;

endmodule

>>> hw/rtl/qsao_project.sv
// Projection pipeline: products, dot sums, and interval min/max per edge axis.
module qsao_project #(
    parameter int COORD_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [COORD_BITS:0]     in_ax [qsao_pkg::NUM_EDGES],
    input  logic signed [COORD_BITS:0]     in_ay [qsao_pkg::NUM_EDGES],
    input  logic signed [COORD_BITS-1:0]   in_x [qsao_pkg::ALL_CORNERS],
    input  logic signed [COORD_BITS-1:0]   in_y [qsao_pkg::ALL_CORNERS],
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [2*COORD_BITS+1:0] out_rmin [qsao_pkg::NUM_EDGES],
    output logic signed [2*COORD_BITS+1:0] out_rmax [qsao_pkg::NUM_EDGES],
    output logic signed [2*COORD_BITS+1:0] out_tmin [qsao_pkg::NUM_EDGES],
    output logic signed [2*COORD_BITS+1:0] out_tmax [qsao_pkg::NUM_EDGES]
);
    import qsao_pkg::*;

    localparam int PW     = 2 * COORD_BITS + 1;
    localparam int DW     = 2 * COORD_BITS + 2;
    localparam int STAGES = 4;
    localparam int HALF   = NUM_CORNERS / 2;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] rdy;

    logic signed [PW-1:0] px_reg [NUM_EDGES][ALL_CORNERS];
    logic signed [PW-1:0] py_reg [NUM_EDGES][ALL_CORNERS];
    logic signed [PW-1:0] px_next [NUM_EDGES][ALL_CORNERS];
    logic signed [PW-1:0] py_next [NUM_EDGES][ALL_CORNERS];
    logic signed [DW-1:0] dot_reg [NUM_EDGES][ALL_CORNERS];
    logic signed [DW-1:0] dot_next [NUM_EDGES][ALL_CORNERS];

    // Pair stage: index q selects the quad (0 reference, 1 test), p the pair
    logic signed [DW-1:0] pmin_reg [NUM_EDGES][2][HALF];
    logic signed [DW-1:0] pmax_reg [NUM_EDGES][2][HALF];
    logic signed [DW-1:0] pmin_next [NUM_EDGES][2][HALF];
    logic signed [DW-1:0] pmax_next [NUM_EDGES][2][HALF];
    logic signed [DW-1:0] fmin_reg [NUM_EDGES][2];
    logic signed [DW-1:0] fmax_reg [NUM_EDGES][2];
    logic signed [DW-1:0] fmin_next [NUM_EDGES][2];
    logic signed [DW-1:0] fmax_next [NUM_EDGES][2];

    // A stage advances when it is empty or the next one advances
    always_comb begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k + 1];
        end
    end

    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int c = 0; c < ALL_CORNERS; c++) begin
                px_next[e][c]  = PW'(in_ax[e]) * PW'(in_x[c]);
                py_next[e][c]  = PW'(in_ay[e]) * PW'(in_y[c]);
                dot_next[e][c] = DW'(px_reg[e][c]) + DW'(py_reg[e][c]);
            end
        end
    end

    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            for (int q = 0; q < 2; q++) begin
                for (int p = 0; p < HALF; p++) begin
                    if (dot_reg[e][q*NUM_CORNERS + 2*p + 1] < dot_reg[e][q*NUM_CORNERS + 2*p]) begin
                        pmin_next[e][q][p] = dot_reg[e][q*NUM_CORNERS + 2*p + 1];
                        pmax_next[e][q][p] = dot_reg[e][q*NUM_CORNERS + 2*p];
                    end else begin
                        pmin_next[e][q][p] = dot_reg[e][q*NUM_CORNERS + 2*p];
                        pmax_next[e][q][p] = dot_reg[e][q*NUM_CORNERS + 2*p + 1];
                    end
                end
                fmin_next[e][q] = (pmin_reg[e][q][1] < pmin_reg[e][q][0]) ?
                                  pmin_reg[e][q][1] : pmin_reg[e][q][0];
                fmax_next[e][q] = (pmax_reg[e][q][1] > pmax_reg[e][q][0]) ?
                                  pmax_reg[e][q][1] : pmax_reg[e][q][0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            px_reg <= px_next;
            py_reg <= py_next;
        end
        if (rdy[1]) begin
            dot_reg <= dot_next;
        end
        if (rdy[2]) begin
            pmin_reg <= pmin_next;
            pmax_reg <= pmax_next;
        end
        if (rdy[3]) begin
            fmin_reg <= fmin_next;
            fmax_reg <= fmax_next;
        end
    end

    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            out_rmin[e] = fmin_reg[e][0];
            out_rmax[e] = fmax_reg[e][0];
            out_tmin[e] = fmin_reg[e][1];
            out_tmax[e] = fmax_reg[e][1];
        end
    end

    assign out_valid = vld_reg[STAGES-1];

endmodule

>>> hw/rtl/qsao_result.sv
// Interval disjointness check, first-separating-edge select and result register.
module qsao_result #(
    parameter int COORD_BITS = 24
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [2*COORD_BITS+1:0] in_rmin [qsao_pkg::NUM_EDGES],
    input  logic signed [2*COORD_BITS+1:0] in_rmax [qsao_pkg::NUM_EDGES],
    input  logic signed [2*COORD_BITS+1:0] in_tmin [qsao_pkg::NUM_EDGES],
    input  logic signed [2*COORD_BITS+1:0] in_tmax [qsao_pkg::NUM_EDGES],
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           out_overlap,
    output qsao_pkg::edge_idx_t            out_edge
);
    import qsao_pkg::*;

    logic [NUM_EDGES-1:0] sep;
    logic                 valid_reg;
    logic                 overlap_reg;
    logic                 overlap_next;
    edge_idx_t            edge_reg;
    edge_idx_t            edge_next;

    assign in_ready = !valid_reg || out_ready;

    // Touching intervals still overlap, so the compares are strict
    always_comb begin
        for (int e = 0; e < NUM_EDGES; e++) begin
            sep[e] = (in_rmax[e] < in_tmin[e]) || (in_tmax[e] < in_rmin[e]);
        end
        overlap_next = !(|sep);
        edge_next    = '0;
        for (int e = NUM_EDGES - 1; e >= 0; e--) begin
            if (sep[e]) begin
                edge_next = EDGE_BITS'(e);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            overlap_reg <= overlap_next;
            edge_reg    <= edge_next;
        end
    end

    assign out_valid   = valid_reg;
    assign out_overlap = overlap_reg;
    assign out_edge    = edge_reg;

endmodule

>>> hw/rtl/quad_separating_axis_overlap_core.sv
// A test word passes the input, axis, product, dot, pair, span and result registers.
// Throughput: one word per cycle on the input; stalls propagate only as far as needed.
// Load words update the reference quad and produce no result; a test right behind sees it.
// The 64 axis-by-coordinate products sit in a single registered stage.
// Reset (aresetn low, synchronous) empties the pipeline and sets the reference quad to zero.
module quad_separating_axis_overlap_core #(
    parameter int COORD_BITS = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // corner0_x, corner0_y, corner1_x, corner1_y, ... corner3_y (24 bits each)
    input  logic [qsao_pkg::S_TDATA_BITS-1:0] s_tdata,
    // kind
    input  logic [qsao_pkg::S_TUSER_BITS-1:0] s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // overlap, separating_edge (2 bits), zero fill
    output logic [qsao_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import qsao_pkg::*;

    localparam int DW = 2 * COORD_BITS + 2;

    logic                         in_valid_reg;
    kind_t                        in_kind_reg;
    logic signed [COORD_BITS-1:0] in_x_reg [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] in_y_reg [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] in_x_next [NUM_CORNERS];
    logic signed [COORD_BITS-1:0] in_y_next [NUM_CORNERS];

    logic                         ax_ready;
    logic                         ax_valid;
    logic signed [COORD_BITS:0]   ax_ax [NUM_EDGES];
    logic signed [COORD_BITS:0]   ax_ay [NUM_EDGES];
    logic signed [COORD_BITS-1:0] ax_x [ALL_CORNERS];
    logic signed [COORD_BITS-1:0] ax_y [ALL_CORNERS];

    logic                         pj_ready;
    logic                         pj_valid;
    logic signed [DW-1:0]         pj_rmin [NUM_EDGES];
    logic signed [DW-1:0]         pj_rmax [NUM_EDGES];
    logic signed [DW-1:0]         pj_tmin [NUM_EDGES];
    logic signed [DW-1:0]         pj_tmax [NUM_EDGES];

    logic                         rs_ready;
    logic                         res_overlap;
    edge_idx_t                    res_edge;

    // Take the low COORD_BITS of each field, or sign-extend it when wider
    always_comb begin
        for (int c = 0; c < NUM_CORNERS; c++) begin
            in_x_next[c] = COORD_BITS'($signed(s_tdata[2*c*FIELD_BITS +: FIELD_BITS]));
            in_y_next[c] = COORD_BITS'($signed(s_tdata[(2*c+1)*FIELD_BITS +: FIELD_BITS]));
        end
    end

    assign s_tready = !in_valid_reg || ax_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_kind_reg <= kind_t'(s_tuser[0]);
            in_x_reg    <= in_x_next;
            in_y_reg    <= in_y_next;
        end
    end

    qsao_axis #(
        .COORD_BITS(COORD_BITS)
    ) u_axis (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_valid_reg),
        .in_ready  (ax_ready),
        .in_kind   (in_kind_reg),
        .in_x      (in_x_reg),
        .in_y      (in_y_reg),
        .out_valid (ax_valid),
        .out_ready (pj_ready),
        .out_ax    (ax_ax),
        .out_ay    (ax_ay),
        .out_x     (ax_x),
        .out_y     (ax_y)
    );

    qsao_project #(
        .COORD_BITS(COORD_BITS)
    ) u_project (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ax_valid),
        .in_ready  (pj_ready),
        .in_ax     (ax_ax),
        .in_ay     (ax_ay),
        .in_x      (ax_x),
        .in_y      (ax_y),
        .out_valid (pj_valid),
        .out_ready (rs_ready),
        .out_rmin  (pj_rmin),
        .out_rmax  (pj_rmax),
        .out_tmin  (pj_tmin),
        .out_tmax  (pj_tmax)
    );

    qsao_result #(
        .COORD_BITS(COORD_BITS)
    ) u_result (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (pj_valid),
        .in_ready    (rs_ready),
        .in_rmin     (pj_rmin),
        .in_rmax     (pj_rmax),
        .in_tmin     (pj_tmin),
        .in_tmax     (pj_tmax),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_overlap (res_overlap),
        .out_edge    (res_edge)
    );

    assign m_tdata = M_TDATA_BITS'({res_edge, res_overlap});

endmodule

>>> sim/quad_separating_axis_overlap_core_tb.sv
// Self-checking testbench for the quad separating-axis overlap core, driven as a stream.
module quad_separating_axis_overlap_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qsao_pkg::*;

    localparam int N_RANDOM   = 1300;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL_WAIT  = 24;
    localparam int MAX_COORD  = 8388607;
    localparam int MIN_COORD  = -8388608;

    typedef logic [NUM_CORNERS-1:0][FIELD_BITS-1:0] corner_vec_t;

    typedef struct packed {
        corner_vec_t x;
        corner_vec_t y;
    } quad_t;

    typedef struct packed {
        logic      overlap;
        edge_idx_t sep_edge;
    } verdict_t;

    typedef struct {
        kind_t    kind;
        quad_t    quad;
        bit       typed;
        verdict_t want;
    } stim_row_t;

    localparam verdict_t VERDICT_OVERLAP = '{1'b1, 2'd0};

    logic                    aclk     = 1'b0;
    logic                    aresetn  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata  = '0;
    logic [S_TUSER_BITS-1:0] s_tuser  = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;

    // Expected verdict typed into the directed table, travels with the word.
    bit       row_typed = 1'b0;
    verdict_t row_want  = VERDICT_OVERLAP;

    quad_t     ref_quad = '0;
    verdict_t  pending_verdicts[$];
    stim_row_t directed[$];
    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        no_idle     = 1'b0;

    quad_separating_axis_overlap_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint coord_val(logic [FIELD_BITS-1:0] c);
        return longint'($signed(c));
    endfunction

    function automatic void project_span(quad_t q, longint ax, longint ay,
                                         output longint lo, output longint hi);
        longint p;
        lo = coord_val(q.x[0]) * ax + coord_val(q.y[0]) * ay;
        hi = lo;
        for (int k = 1; k < NUM_CORNERS; k++) begin
            p = coord_val(q.x[k]) * ax + coord_val(q.y[k]) * ay;
            if (p < lo) lo = p;
            if (p > hi) hi = p;
        end
    endfunction

    // Walk the reference edges; the first axis with strictly disjoint spans separates.
    function automatic verdict_t judge_quad(quad_t r, quad_t q);
        verdict_t v;
        longint   ax, ay, rlo, rhi, tlo, thi;
        int       j;
        bit       found;
        v     = VERDICT_OVERLAP;
        found = 1'b0;
        for (int i = 0; i < NUM_EDGES; i++) begin
            if (!found) begin
                j  = (i + 1) % NUM_CORNERS;
                ax = -(coord_val(r.y[j]) - coord_val(r.y[i]));
                ay = coord_val(r.x[j]) - coord_val(r.x[i]);
                project_span(r, ax, ay, rlo, rhi);
                project_span(q, ax, ay, tlo, thi);
                if (rhi < tlo || thi < rlo) begin
                    found      = 1'b1;
                    v.overlap  = 1'b0;
                    v.sep_edge = edge_idx_t'(i);
                end
            end
        end
        return v;
    endfunction

    function automatic logic [S_TDATA_BITS-1:0] pack_quad(quad_t q);
        logic [S_TDATA_BITS-1:0] w;
        w = '0;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            w[2*i*FIELD_BITS +: FIELD_BITS]     = q.x[i];
            w[(2*i+1)*FIELD_BITS +: FIELD_BITS] = q.y[i];
        end
        return w;
    endfunction

    function automatic quad_t unpack_quad(logic [S_TDATA_BITS-1:0] w);
        quad_t q;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            q.x[i] = w[2*i*FIELD_BITS +: FIELD_BITS];
            q.y[i] = w[(2*i+1)*FIELD_BITS +: FIELD_BITS];
        end
        return q;
    endfunction

    function automatic quad_t quad_of(int x0, int y0, int x1, int y1,
                                      int x2, int y2, int x3, int y3);
        quad_t q;
        q.x[0] = FIELD_BITS'(x0); q.y[0] = FIELD_BITS'(y0);
        q.x[1] = FIELD_BITS'(x1); q.y[1] = FIELD_BITS'(y1);
        q.x[2] = FIELD_BITS'(x2); q.y[2] = FIELD_BITS'(y2);
        q.x[3] = FIELD_BITS'(x3); q.y[3] = FIELD_BITS'(y3);
        return q;
    endfunction

    function automatic int rand_coord();
        return int'($urandom) >>> 8;
    endfunction

    function automatic quad_t random_quad();
        quad_t q;
        for (int i = 0; i < NUM_CORNERS; i++) begin
            q.x[i] = FIELD_BITS'(rand_coord());
            q.y[i] = FIELD_BITS'(rand_coord());
        end
        return q;
    endfunction

    function automatic int pick_spread();
        case ($urandom_range(0, 9))
            0, 1, 2:       return 16;
            3, 4, 5, 6:    return 4096;
            7, 8:          return 1 << 20;
            default: begin
                return 1 << 22;
            end
        endcase
    endfunction

    // Jittered rectangle, random start corner and winding; wraps at the field width.
    function automatic quad_t rect_quad(int cx, int cy, int spread);
        quad_t q;
        int    hw, hh, start, idx, jit;
        bit    rev;
        int    px[4];
        int    py[4];
        hw    = int'($urandom_range(0, spread));
        hh    = int'($urandom_range(0, spread));
        jit   = spread / 4;
        start = int'($urandom_range(0, 3));
        rev   = 1'($urandom_range(0, 1));
        px[0] = cx - hw; px[1] = cx + hw; px[2] = cx + hw; px[3] = cx - hw;
        py[0] = cy - hh; py[1] = cy - hh; py[2] = cy + hh; py[3] = cy + hh;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            idx    = rev ? (start - k + 4) % 4 : (start + k) % 4;
            q.x[k] = FIELD_BITS'(px[idx] + int'($urandom_range(0, 2 * jit)) - jit);
            q.y[k] = FIELD_BITS'(py[idx] + int'($urandom_range(0, 2 * jit)) - jit);
        end
        return q;
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (no_idle) return 0;
        if (r < 60) return 0;
        if (r < 93) return int'($urandom_range(1, 3));
        return int'($urandom_range(8, 40));
    endfunction

    task automatic add_row(kind_t kind, quad_t q, bit typed, verdict_t want);
        stim_row_t row;
        row.kind  = kind;
        row.quad  = q;
        row.typed = typed;
        row.want  = want;
        directed.push_back(row);
    endtask

    task automatic send_word(kind_t kind, quad_t q, bit typed, verdict_t want);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid  = 1'b1;
        s_tuser   = kind;
        s_tdata   = pack_quad(q);
        row_typed = typed;
        row_want  = want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold the sender off until every outstanding verdict has come back.
    task automatic drain_verdicts();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_verdicts.size() != 0) @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        quad_t    q;
        verdict_t got, want;
        bit       moved;
        moved = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                q = unpack_quad(s_tdata);
                if (kind_t'(s_tuser[0]) == KIND_LOAD) begin
                    ref_quad = q;
                end else begin
                    want = row_typed ? row_want : judge_quad(ref_quad, q);
                    pending_verdicts.push_back(want);
                end
            end
            if (m_tvalid && m_tready) begin
                moved        = 1'b1;
                got.overlap  = m_tdata[0];
                got.sep_edge = m_tdata[2:1];
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result word overlap %0d edge %0d",
                             $time, got.overlap, got.sep_edge);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.overlap !== want.overlap) begin
                        mismatches++;
                        $display("%0t: overlap mismatch expected %0d actual %0d",
                                 $time, want.overlap, got.overlap);
                    end
                    if (got.sep_edge !== want.sep_edge) begin
                        mismatches++;
                        $display("%0t: separating_edge mismatch expected %0d actual %0d",
                                 $time, want.sep_edge, got.sep_edge);
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(negedge aclk);
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: random stalls, mostly short, some long; steady during no-idle stretches.
    initial begin
        int span;
        span = 0;
        forever begin
            @(negedge aclk);
            if (no_idle) begin
                m_tready = 1'b1;
                span     = 0;
            end else if (span > 0) begin
                span--;
            end else if ($urandom_range(0, 3) != 0) begin
                m_tready = 1'b1;
                span     = int'($urandom_range(0, 12));
            end else begin
                m_tready = 1'b0;
                span     = ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                                       : int'($urandom_range(0, 2));
            end
        end
    end

    initial begin
        int    r, spread, ref_cx, ref_cy, ref_spread, cx, cy;
        quad_t q;
        ref_cx     = 0;
        ref_cy     = 0;
        ref_spread = 16;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Test against the reset quad: every axis is zero, so always overlap.
        add_row(KIND_TEST, quad_of(100, -200, 300, 400, -500, 600, 700, -800),
                1'b1, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD,
                                   MAX_COORD, MIN_COORD, MIN_COORD, MAX_COORD),
                1'b1, VERDICT_OVERLAP);
        // Unit square, then the same, shifted, touching and separated quads.
        add_row(KIND_LOAD, quad_of(0, 0, 256, 0, 256, 256, 0, 256), 1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(0, 0, 256, 0, 256, 256, 0, 256), 1'b1, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(512, 0, 768, 0, 768, 256, 512, 256), 1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(256, 0, 512, 0, 512, 256, 256, 256), 1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(-257, 0, -1, 0, -1, 256, -257, 256), 1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(0, 300, 256, 300, 256, 556, 0, 556), 1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(0, -400, 256, -400, 256, -1, 0, -1), 1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(128, 128, 129, 128, 129, 129, 128, 129),
                1'b0, VERDICT_OVERLAP);
        // Fully collapsed reference: no axis can separate.
        add_row(KIND_LOAD, quad_of(1000, -1000, 1000, -1000, 1000, -1000, 1000, -1000),
                1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(MAX_COORD, 0, MAX_COORD, 5, MAX_COORD - 9, 5,
                                   MAX_COORD - 9, 0),
                1'b1, VERDICT_OVERLAP);
        // Reference with one zero-length edge.
        add_row(KIND_LOAD, quad_of(0, 0, 0, 0, 256, 256, 0, 256), 1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(300, -50, 400, -50, 400, 10, 300, 10),
                1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(10, 200, 20, 200, 20, 220, 10, 220),
                1'b0, VERDICT_OVERLAP);
        // Extreme reference and extreme test quads.
        add_row(KIND_LOAD, quad_of(MIN_COORD, MIN_COORD, MAX_COORD, MIN_COORD,
                                   MAX_COORD, MAX_COORD, MIN_COORD, MAX_COORD),
                1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD,
                                   MIN_COORD, MIN_COORD, MIN_COORD, MIN_COORD),
                1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD,
                                   MAX_COORD, MAX_COORD, MAX_COORD, MAX_COORD),
                1'b0, VERDICT_OVERLAP);
        add_row(KIND_LOAD, quad_of(MAX_COORD, MIN_COORD, MIN_COORD, MAX_COORD,
                                   MAX_COORD, MAX_COORD, MIN_COORD, MIN_COORD),
                1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(5592405, -5592406, -5592406, 5592405,
                                   5592405, 5592405, -5592406, -5592406),
                1'b0, VERDICT_OVERLAP);
        // Diamond with negative coordinates, tested right behind its load.
        add_row(KIND_LOAD, quad_of(-1000, -2000, -500, -1500, -1000, -1000, -1500, -1500),
                1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(-600, -1100, -400, -1100, -400, -900, -600, -900),
                1'b0, VERDICT_OVERLAP);
        add_row(KIND_TEST, quad_of(-1100, -1600, -900, -1600, -900, -1400, -1100, -1400),
                1'b0, VERDICT_OVERLAP);

        foreach (directed[i])
            send_word(directed[i].kind, directed[i].quad, directed[i].typed, directed[i].want);
        drain_verdicts();

        for (int n = 0; n < N_RANDOM; n++) begin
            no_idle = (n >= 700 && n < 850);
            if (n == 400 || $urandom_range(0, 199) == 0)
                drain_verdicts();
            r = int'($urandom_range(0, 99));
            if (r < 12) begin
                ref_spread = pick_spread();
                ref_cx     = rand_coord();
                ref_cy     = rand_coord();
                q          = rect_quad(ref_cx, ref_cy, ref_spread);
                send_word(KIND_LOAD, q, 1'b0, VERDICT_OVERLAP);
            end else if (r < 82) begin
                spread = pick_spread();
                cx = ref_cx + int'($urandom_range(0, 6 * ref_spread)) - 3 * ref_spread;
                cy = ref_cy + int'($urandom_range(0, 6 * ref_spread)) - 3 * ref_spread;
                q  = rect_quad(cx, cy, spread);
                send_word(KIND_TEST, q, 1'b0, VERDICT_OVERLAP);
            end else if (r < 94) begin
                send_word(KIND_TEST, random_quad(), 1'b0, VERDICT_OVERLAP);
            end else begin
                send_word(KIND_LOAD, random_quad(), 1'b0, VERDICT_OVERLAP);
            end
        end
        no_idle = 1'b0;

        drain_verdicts();
        repeat (TAIL_WAIT) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/qsao_pkg.sv
hw/rtl/qsao_axis.sv
hw/rtl/qsao_project.sv
hw/rtl/qsao_result.sv
hw/rtl/quad_separating_axis_overlap_core.sv
sim/quad_separating_axis_overlap_core_tb.sv
